[rtl/rsort_pkg.sv]
`timescale 1ns / 1ps

package rsort_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int REC_W       = 40;
  localparam int KEY_W       = 40;

  // Packed so that the last field (year) sits in the lowest bits.
  typedef struct packed {
    logic signed [7:0] temp;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [11:0]       year;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Date key: year<<28 | month<<24 | day<<16 | hour<<8 | minute.
  function automatic logic [KEY_W-1:0] date_key(input rec_t r);
    date_key = {r.year, r.month, 3'b000, r.day, 3'b000, r.hour, 2'b00, r.minute};
  endfunction

  // True when key(a) >= key(b) under the selected mode.
  function automatic logic key_ge(input logic mode, input rec_t a, input rec_t b);
    if (mode) begin
      key_ge = (date_key(a) >= date_key(b));
    end else begin
      key_ge = (a.temp >= b.temp);
    end
  endfunction

endpackage

[rtl/record_sorter_by_temp_or_date.sv]
`timescale 1ns / 1ps
// Load: one record beat per cycle while loading; the last beat starts the sort.
// Sort: one compare per cycle, set by the one read and one write port of the
//   record memory.
// Drain: each sorted record is read, loaded, then handed off; the next read starts only after the sink takes it.
// Reset (rst_n low, synchronous): empties the store, returns to loading, selects
//   temperature keys; the record memory itself is not cleared.

module record_sorter_by_temp_or_date (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: sort_key_mode
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // input records
  input  logic        in_tvalid,
  output logic        in_tready,
  // rec_year[11:0], rec_month[15:12], rec_day[20:16], rec_hour[25:21],
  // rec_minute[31:26], rec_temp[39:32]
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  // sorted records
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_year[11:0], out_month[15:12], out_day[20:16], out_hour[25:21],
  // out_minute[31:26], out_temp[39:32]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  logic                sort_key_mode_r;
  rsort_pkg::rec_t     in_rec;
  rsort_pkg::rec_t     out_rec;
  rsort_pkg::mem_req_t mem_req;
  rsort_pkg::rec_t     mem_rdata;

  // Hold the key mode; it takes effect at the next last beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_key_mode_r <= 1'b0;
    end else if (cfg_we) begin
      sort_key_mode_r <= cfg_wdata;
    end
  end

  assign in_rec    = rsort_pkg::rec_t'(in_tdata);
  assign out_tdata = 40'(out_rec);

  // Sequencer: load, exchange sort in place, drain in order.
  rsort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sort_mode  (sort_key_mode_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_rec     (in_rec),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_rec    (out_rec),
    .out_last   (out_tlast),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // Record memory, registered read.
  rsort_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

[rtl/rsort_store.sv]
`timescale 1ns / 1ps

module rsort_store (
  input  logic               clk,
  input  rsort_pkg::mem_req_t req,
  output rsort_pkg::rec_t    rdata
);

  rsort_pkg::rec_t mem [rsort_pkg::MAX_RECORDS];
  rsort_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rsort_ctrl.sv]
`timescale 1ns / 1ps

module rsort_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sort_mode,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rsort_pkg::rec_t     in_rec,
  input  logic                in_last,
  output logic                out_tvalid,
  input  logic                out_tready,
  output rsort_pkg::rec_t     out_rec,
  output logic                out_last,
  output rsort_pkg::mem_req_t mem_req,
  input  rsort_pkg::rec_t     mem_rdata
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WR_I,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

  state_t                          state_r;
  logic [rsort_pkg::CNT_W-1:0]     count_r;
  logic [rsort_pkg::CNT_W-1:0]     n_r;
  logic [rsort_pkg::ADDR_W-1:0]    i_r;
  logic [rsort_pkg::ADDR_W-1:0]    j_r;
  logic [rsort_pkg::ADDR_W-1:0]    k_r;
  logic                            mode_r;
  rsort_pkg::rec_t                 cur_r;
  rsort_pkg::rec_t                 out_rec_r;
  logic                            out_valid_r;
  logic                            out_last_r;

  logic                            accept;
  logic                            has_room;
  logic [rsort_pkg::CNT_W-1:0]     count_inc;
  logic                            swap;
  logic                            j_end;
  logic                            i_end;
  logic                            k_end;

  assign in_tready = (state_r == ST_LOAD);
  assign accept    = in_tvalid && in_tready;
  assign has_room  = (count_r < rsort_pkg::CNT_W'(rsort_pkg::MAX_RECORDS));
  assign count_inc = has_room ? count_r + rsort_pkg::CNT_W'(1) : count_r;
  assign swap      = rsort_pkg::key_ge(mode_r, cur_r, mem_rdata);
  assign j_end     = (rsort_pkg::CNT_W'(j_r) + rsort_pkg::CNT_W'(1) == n_r);
  assign i_end     = (rsort_pkg::CNT_W'(i_r) + rsort_pkg::CNT_W'(2) == n_r);
  assign k_end     = (rsort_pkg::CNT_W'(k_r) + rsort_pkg::CNT_W'(1) == n_r);

  // Single read and single write per cycle; the addresses in flight never collide.
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = in_rec;
    case (state_r)
      ST_LOAD: begin
        mem_req.we    = accept && has_room;
        mem_req.waddr = count_r[rsort_pkg::ADDR_W-1:0];
      end
      ST_RD_I: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = i_r;
      end
      ST_LD_I: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = i_r + rsort_pkg::ADDR_W'(1);
      end
      ST_CMP: begin
        mem_req.we    = swap;
        mem_req.waddr = j_r;
        mem_req.wdata = cur_r;
        mem_req.re    = !j_end;
        mem_req.raddr = j_r + rsort_pkg::ADDR_W'(1);
      end
      ST_WR_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        mem_req.wdata = cur_r;
      end
      ST_OUT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = k_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (accept) begin
            count_r <= count_inc;
            if (in_last) begin
              // Freeze the key mode and the set size for this sort.
              mode_r <= sort_mode;
              n_r    <= count_inc;
              i_r    <= '0;
              k_r    <= '0;
              state_r <= (count_inc > rsort_pkg::CNT_W'(1)) ? ST_RD_I : ST_OUT_RD;
            end
          end
        end
        ST_RD_I: begin
          state_r <= ST_LD_I;
        end
        ST_LD_I: begin
          cur_r   <= mem_rdata;
          j_r     <= i_r + rsort_pkg::ADDR_W'(1);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (swap) begin
            cur_r <= mem_rdata;
          end
          if (j_end) begin
            state_r <= ST_WR_I;
          end else begin
            j_r <= j_r + rsort_pkg::ADDR_W'(1);
          end
        end
        ST_WR_I: begin
          if (i_end) begin
            state_r <= ST_OUT_RD;
          end else begin
            i_r     <= i_r + rsort_pkg::ADDR_W'(1);
            state_r <= ST_RD_I;
          end
        end
        ST_OUT_RD: begin
          state_r <= ST_OUT_LD;
        end
        ST_OUT_LD: begin
          out_rec_r   <= mem_rdata;
          out_last_r  <= k_end;
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              state_r <= ST_LOAD;
            end else begin
              k_r     <= k_r + rsort_pkg::ADDR_W'(1);
              state_r <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_rec    = out_rec_r;
  assign out_last   = out_last_r;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rsort_pkg::*;

  localparam int N_DIR = 21;

  // One expected output beat: the record plus its end-of-set flag.
  typedef struct {
    rec_t rec;
    bit   last;
  } sorted_beat_t;

  // Directed stimulus row. When set_mode is high the key mode is written
  // (block idle) before the row goes out. Typed rows carry their own result.
  typedef struct {
    bit   set_mode;
    bit   mode;
    rec_t rec;
    bit   last;
    bit   typed;
    rec_t exp;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // year, month, day, hour, minute, temp from bit 0 up
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // year, month, day, hour, minute, temp from bit 0 up
  logic        out_tlast;

  record_sorter_by_temp_or_date dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Sorter shadow: held records, their count and the key mode in force.
  rec_t         held_recs[MAX_RECORDS];
  int           held_count;
  bit           key_mode;
  sorted_beat_t sorted_q[$];

  dir_row_t     dir_rows[N_DIR];
  rec_t         prev_rec;
  int           src_burst;
  int           sink_run;
  int           sink_stall;

  int           errors;
  int           sets_done;
  int           date_sets;
  int           recs_sent;
  int           recs_dropped;
  int           beats_seen;

  sorted_beat_t chk_want;
  rec_t         chk_got;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous hard stop; a healthy run ends far earlier.
  initial begin
    #2_000_000;
    $display("Timeout: sorter stopped making progress");
    $display("Test completed with failures");
    $finish;
  end

  function automatic rec_t stamp_rec(int y, int mo, int d, int h, int mi, int t);
    rec_t r;
    r.year   = y[11:0];
    r.month  = mo[3:0];
    r.day    = d[4:0];
    r.hour   = h[4:0];
    r.minute = mi[5:0];
    r.temp   = t[7:0];
    return r;
  endfunction

  // Packed date key, built 64 bits wide so no field overlaps another.
  function automatic logic [63:0] date_order_key(rec_t r);
    logic [63:0] k;
    k = ({52'd0, r.year} << 28) | ({60'd0, r.month} << 24) | ({59'd0, r.day} << 16) |
        ({59'd0, r.hour} << 8) | {58'd0, r.minute};
    return k;
  endfunction

  function automatic bit key_not_below(bit by_date, rec_t a, rec_t b);
    if (by_date) begin
      return date_order_key(a) >= date_order_key(b);
    end
    return $signed(a.temp) >= $signed(b.temp);
  endfunction

  // Apply one accepted beat to the shadow. On the last beat, queue the typed result, or run the
  // same exchange sort as the block and queue every sorted record.
  task automatic store_record(input rec_t r, input bit last, input bit typed,
                              input rec_t typed_exp);
    rec_t         t;
    sorted_beat_t b;
    int           i;
    int           j;
    if (held_count < MAX_RECORDS) begin
      held_recs[held_count] = r;
      held_count++;
    end else begin
      recs_dropped++;
    end
    if (last) begin
      if (typed) begin
        b.rec  = typed_exp;
        b.last = 1'b1;
        sorted_q.push_back(b);
      end else begin
        for (i = 0; i < held_count; i++) begin
          for (j = i + 1; j < held_count; j++) begin
            if (key_not_below(key_mode, held_recs[i], held_recs[j])) begin
              t            = held_recs[i];
              held_recs[i] = held_recs[j];
              held_recs[j] = t;
            end
          end
        end
        for (i = 0; i < held_count; i++) begin
          b.rec  = held_recs[i];
          b.last = (i == held_count - 1);
          sorted_q.push_back(b);
        end
      end
      held_count = 0;
      sets_done++;
      if (key_mode) date_sets++;
    end
  endtask

  // Source gap: mostly none or short, a few long, with runs of back-to-back beats.
  function automatic int next_src_gap();
    int r;
    if (src_burst > 0) begin
      src_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      src_burst = $urandom_range(8, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random record: mostly sane timestamps, some out-of-range noise, and
  // frequent key collisions so tie ordering gets exercised.
  function automatic rec_t rand_record();
    rec_t r;
    r.year   = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(2020, 2023))
                                          : 12'($urandom_range(0, 4095));
    r.month  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12))
                                            : 4'($urandom_range(0, 15));
    r.day    = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 28))
                                            : 5'($urandom_range(0, 31));
    r.hour   = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23))
                                            : 5'($urandom_range(0, 31));
    r.minute = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 59))
                                            : 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.temp = 8'($urandom_range(0, 6) - 3);
      4, 5, 6, 7, 8: r.temp = 8'($urandom_range(0, 85) - 40);
      default: r.temp = 8'($urandom_range(0, 255));
    endcase
    // Reuse the previous timestamp now and then: equal date keys.
    if ($urandom_range(0, 99) < 15) begin
      r.year   = prev_rec.year;
      r.month  = prev_rec.month;
      r.day    = prev_rec.day;
      r.hour   = prev_rec.hour;
      r.minute = prev_rec.minute;
    end
    prev_rec = r;
    return r;
  endfunction

  // Called and returns at a falling edge. Hold the beat until accepted,
  // then update the shadow and idle for a random gap.
  task automatic send_beat(input rec_t r, input bit last, input bit typed,
                           input rec_t typed_exp);
    int gap;
    in_tdata  = r;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    store_record(r, last, typed, typed_exp);
    recs_sent++;
    @(negedge clk);
    gap = next_src_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = 40'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain every queued result, then give the block time to settle.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we    = 1'b0;
    key_mode  = m;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sink: one tready decision per falling edge. Short runs and stalls,
  // occasionally long ones, so gaps land on every phase of the drain.
  initial begin
    out_tready = 1'b0;
    sink_run   = 0;
    sink_stall = 0;
    forever begin
      @(negedge clk);
      if (sink_run == 0 && sink_stall == 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: sink_run = $urandom_range(1, 4);
          11, 12, 13, 14, 15, 16: sink_stall = $urandom_range(1, 3);
          17, 18: sink_run = $urandom_range(20, 60);
          default: sink_stall = $urandom_range(20, 50);
        endcase
      end
      if (sink_run > 0) begin
        out_tready = 1'b1;
        sink_run--;
      end else begin
        out_tready = 1'b0;
        sink_stall--;
      end
    end
  end

  // Compare each output beat with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      chk_got = out_tdata;
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected sorted beat, expected none, actual %h last %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        chk_want = sorted_q.pop_front();
        check_field("year", chk_want.rec.year, chk_got.year);
        check_field("month", chk_want.rec.month, chk_got.month);
        check_field("day", chk_want.rec.day, chk_got.day);
        check_field("hour", chk_want.rec.hour, chk_got.hour);
        check_field("minute", chk_want.rec.minute, chk_got.minute);
        check_field("temp", $signed(chk_want.rec.temp), $signed(chk_got.temp));
        check_field("last", chk_want.last, out_tlast);
      end
    end
  end

  initial begin
    int   i;
    int   k;
    int   rand_items;
    int   set_len;
    bit   overflow_done;
    rec_t r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    held_count   = 0;
    key_mode     = 1'b0;
    prev_rec     = '0;
    src_burst    = 0;
    errors       = 0;
    sets_done    = 0;
    date_sets    = 0;
    recs_sent    = 0;
    recs_dropped = 0;
    beats_seen   = 0;

    // Single-record sets come straight back, so their results are typed in.
    dir_rows[0]  = '{1'b1, 1'b0, stamp_rec(0, 0, 0, 0, 0, 0), 1'b1, 1'b1,
                     stamp_rec(0, 0, 0, 0, 0, 0)};
    dir_rows[1]  = '{1'b1, 1'b1, stamp_rec(4095, 15, 31, 31, 63, 127), 1'b1, 1'b1,
                     stamp_rec(4095, 15, 31, 31, 63, 127)};
    dir_rows[2]  = '{1'b1, 1'b0, stamp_rec(0, 0, 0, 0, 0, -128), 1'b1, 1'b1,
                     stamp_rec(0, 0, 0, 0, 0, -128)};
    // Temperature set: both extremes, sign boundary and duplicate keys.
    dir_rows[3]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 1, 0, 0, 127), 1'b0, 1'b0, '0};
    dir_rows[4]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 2, 0, 0, -128), 1'b0, 1'b0, '0};
    dir_rows[5]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 3, 0, 0, 5), 1'b0, 1'b0, '0};
    dir_rows[6]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 4, 0, 0, 0), 1'b0, 1'b0, '0};
    dir_rows[7]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 5, 0, 0, 5), 1'b0, 1'b0, '0};
    dir_rows[8]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 6, 0, 0, -1), 1'b0, 1'b0, '0};
    dir_rows[9]  = '{1'b0, 1'b0, stamp_rec(2020, 1, 7, 0, 0, -128), 1'b1, 1'b0, '0};
    // Date set: equal keys, all-zero and all-ones stamps, out-of-range fields.
    dir_rows[10] = '{1'b1, 1'b1, stamp_rec(2024, 3, 15, 10, 30, 1), 1'b0, 1'b0, '0};
    dir_rows[11] = '{1'b0, 1'b0, stamp_rec(2024, 3, 15, 10, 30, 2), 1'b0, 1'b0, '0};
    dir_rows[12] = '{1'b0, 1'b0, stamp_rec(0, 0, 0, 0, 0, 3), 1'b0, 1'b0, '0};
    dir_rows[13] = '{1'b0, 1'b0, stamp_rec(4095, 15, 31, 31, 63, 4), 1'b0, 1'b0, '0};
    dir_rows[14] = '{1'b0, 1'b0, stamp_rec(2024, 13, 1, 24, 60, 5), 1'b0, 1'b0, '0};
    dir_rows[15] = '{1'b0, 1'b0, stamp_rec(2023, 12, 31, 23, 59, 6), 1'b0, 1'b0, '0};
    dir_rows[16] = '{1'b0, 1'b0, stamp_rec(2024, 3, 15, 10, 29, 7), 1'b0, 1'b0, '0};
    dir_rows[17] = '{1'b0, 1'b0, stamp_rec(2024, 3, 15, 10, 30, 8), 1'b1, 1'b0, '0};
    // All keys equal: output order is purely the exchange pattern.
    dir_rows[18] = '{1'b1, 1'b0, stamp_rec(1, 1, 1, 1, 1, 20), 1'b0, 1'b0, '0};
    dir_rows[19] = '{1'b0, 1'b0, stamp_rec(2, 2, 2, 2, 2, 20), 1'b0, 1'b0, '0};
    dir_rows[20] = '{1'b0, 1'b0, stamp_rec(3, 3, 3, 3, 3, 20), 1'b1, 1'b0, '0};

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].set_mode) begin
        wait_idle();
        write_mode(dir_rows[i].mode);
      end
      send_beat(dir_rows[i].rec, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp);
    end

    // Random sets, mostly small; one overflows the store so the trailing
    // beats (the last one included) get dropped but still trigger the sort.
    rand_items    = 0;
    overflow_done = 1'b0;
    while (rand_items < 90) begin
      if (!overflow_done && rand_items >= 15) begin
        set_len       = MAX_RECORDS + $urandom_range(1, 2);
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        set_len = $urandom_range(10, 16);
      end else begin
        set_len = $urandom_range(1, 6);
      end
      wait_idle();
      write_mode(1'($urandom_range(0, 1)));
      for (k = 0; k < set_len; k++) begin
        r = rand_record();
        send_beat(r, k == set_len - 1, 1'b0, '0);
      end
      rand_items += set_len;
    end

    // Drain, then watch a while longer for stray beats.
    in_tvalid = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sorted %0d record sets (%0d keyed by date) from %0d input records;",
             sets_done, date_sets, recs_sent);
    $display("checked %0d output beats, %0d records dropped on a full store.",
             beats_seen, recs_dropped);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rsort_pkg.sv
rtl/rsort_store.sv
rtl/rsort_ctrl.sv
rtl/record_sorter_by_temp_or_date.sv
test/tb_top.sv
